// ===== hdl/ctre_pkg.sv =====
// Shared types, codes and a helper function for the color tolerance run extractor.
package ctre_pkg;

    localparam int PIXEL_W = 32;
    localparam int COUNT_W = 15;
    localparam int COORD_W = 16;
    localparam int TOL_W   = 8;
    localparam int FMT_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RESULT_W = 3 * COORD_W;

    localparam logic [FMT_W-1:0] FMT_RGBA    = 2'd0;
    localparam logic [FMT_W-1:0] FMT_GRAY    = 2'd1;
    localparam logic [FMT_W-1:0] FMT_INDEXED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd6;

    typedef struct packed {
        logic [COORD_W-1:0] run_right;
        logic [COORD_W-1:0] run_left;
        logic [COORD_W-1:0] run_row;
    } t_run;

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return d;
        end
    endfunction

endpackage

// ===== hdl/color_tolerance_run_extractor_unit.sv =====
// Color key match and horizontal run extractor, one pixel per cycle.
// The pixel ending a run passes through the input register and then the result register before the run is on m_axis.
// Throughput: one pixel per cycle; an input register and a result register
// separate the two sides, so input is stalled only while a result waits unread.
// Reset (synchronous, active low): clears counters, open run, valid flags and
// returns the configuration registers to rgba, key 0, exact match, 1x1 region at 0,0.
module color_tolerance_run_extractor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ctre_pkg::PIXEL_W-1:0]        s_axis_tdata,  // pixel[31:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ctre_pkg::RESULT_W-1:0]       m_axis_tdata,  // run_right, run_left, run_row
    input  logic                                i_cfg_wr_en,
    input  logic [ctre_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ctre_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic [ctre_pkg::FMT_W-1:0]   r_format;
    logic [ctre_pkg::PIXEL_W-1:0] r_key;
    logic [ctre_pkg::TOL_W-1:0]   r_tol;
    logic [ctre_pkg::COUNT_W-1:0] r_left;
    logic [ctre_pkg::COUNT_W-1:0] r_top;
    logic [ctre_pkg::COUNT_W-1:0] r_width;
    logic [ctre_pkg::COUNT_W-1:0] r_height;

    logic                         r_in_valid;
    logic [ctre_pkg::PIXEL_W-1:0] r_in_pixel;

    logic [ctre_pkg::COUNT_W-1:0] r_col;
    logic [ctre_pkg::COUNT_W-1:0] r_row;
    logic                         r_run_open;
    logic [ctre_pkg::COORD_W-1:0] r_run_start;

    logic                         r_out_valid;
    ctre_pkg::t_run               r_out;

    logic                         advance;
    logic                         match;
    logic                         last_col;
    logic                         last_row;
    logic [ctre_pkg::COORD_W-1:0] x;
    logic [ctre_pkg::COORD_W-1:0] y;
    logic                         emit;
    ctre_pkg::t_run               n_out;
    logic                         n_run_open;
    logic [ctre_pkg::COORD_W-1:0] n_run_start;
    logic [ctre_pkg::COUNT_W-1:0] n_col;
    logic [ctre_pkg::COUNT_W-1:0] n_row;

    logic [7:0]                   d0, d1, d2, d3;
    logic                         within0, within1, within2, within3;
    logic                         rgba_clear, gray_clear;
    logic [ctre_pkg::PIXEL_W:0]   idx_diff;
    logic [ctre_pkg::PIXEL_W-1:0] idx_abs;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // per-channel distances
    always_comb begin
        d0 = ctre_pkg::abs_diff8(r_in_pixel[7:0],   r_key[7:0]);
        d1 = ctre_pkg::abs_diff8(r_in_pixel[15:8],  r_key[15:8]);
        d2 = ctre_pkg::abs_diff8(r_in_pixel[23:16], r_key[23:16]);
        d3 = ctre_pkg::abs_diff8(r_in_pixel[31:24], r_key[31:24]);
        within0 = d0 <= r_tol;
        within1 = d1 <= r_tol;
        within2 = d2 <= r_tol;
        within3 = d3 <= r_tol;
        rgba_clear = (r_in_pixel[31:24] == 8'd0) && (r_key[31:24] == 8'd0);
        gray_clear = (r_in_pixel[15:8] == 8'd0) && (r_key[15:8] == 8'd0);
        idx_diff = {1'b0, r_key} - {25'd0, r_in_pixel[7:0]};
        idx_abs  = idx_diff[ctre_pkg::PIXEL_W] ? (~idx_diff[ctre_pkg::PIXEL_W-1:0] + 32'd1)
                                               : idx_diff[ctre_pkg::PIXEL_W-1:0];
    end

    always_comb begin
        case (r_format)
            ctre_pkg::FMT_RGBA: begin
                if (r_tol == 8'd0) begin
                    match = (r_in_pixel == r_key) || rgba_clear;
                end else begin
                    match = rgba_clear || (within0 && within1 && within2 && within3);
                end
            end
            ctre_pkg::FMT_GRAY: begin
                if (r_tol == 8'd0) begin
                    match = ({16'd0, r_in_pixel[15:0]} == r_key) || gray_clear;
                end else begin
                    match = gray_clear || (within0 && within1);
                end
            end
            ctre_pkg::FMT_INDEXED: begin
                match = idx_abs <= {24'd0, r_tol};
            end
            default: begin
                match = 1'b0;
            end
        endcase
    end

    // counters and open run
    always_comb begin
        x        = {1'b0, r_left} + {1'b0, r_col};
        y        = {1'b0, r_top} + {1'b0, r_row};
        last_col = ({1'b0, r_col} + 16'd1) >= {1'b0, r_width};
        last_row = ({1'b0, r_row} + 16'd1) >= {1'b0, r_height};

        n_run_open  = r_run_open;
        n_run_start = r_run_start;
        emit        = 1'b0;
        n_out.run_row   = y;
        n_out.run_left  = r_run_start;
        n_out.run_right = x;

        if (match) begin
            if (!r_run_open) begin
                n_run_open  = 1'b1;
                n_run_start = x;
                n_out.run_left = x;
            end
            if (last_col) begin
                emit       = 1'b1;
                n_run_open = 1'b0;
            end
        end else if (r_run_open) begin
            emit            = 1'b1;
            n_run_open      = 1'b0;
            n_out.run_right = x - 16'd1;
        end

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : (r_row + 15'd1);
        end else begin
            n_col = r_col + 15'd1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= ctre_pkg::FMT_RGBA;
            r_key    <= '0;
            r_tol    <= '0;
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= 15'd1;
            r_height <= 15'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ctre_pkg::REG_PIXEL_FORMAT:  r_format <= i_cfg_wdata[ctre_pkg::FMT_W-1:0];
                ctre_pkg::REG_KEY_COLOR:     r_key    <= i_cfg_wdata;
                ctre_pkg::REG_TOLERANCE:     r_tol    <= i_cfg_wdata[ctre_pkg::TOL_W-1:0];
                ctre_pkg::REG_REGION_LEFT:   r_left   <= i_cfg_wdata[ctre_pkg::COUNT_W-1:0];
                ctre_pkg::REG_REGION_TOP:    r_top    <= i_cfg_wdata[ctre_pkg::COUNT_W-1:0];
                ctre_pkg::REG_REGION_WIDTH:  r_width  <= i_cfg_wdata[ctre_pkg::COUNT_W-1:0];
                ctre_pkg::REG_REGION_HEIGHT: r_height <= i_cfg_wdata[ctre_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= emit;
                r_col       <= n_col;
                r_row       <= n_row;
                r_run_open  <= n_run_open;
                r_run_start <= n_run_start;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_pixel <= s_axis_tdata;
        end
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

endmodule
